// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EMI_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EMI_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EMI_ASSERT_IMP(label, clk, rstn, ante, cons)
`define EMI_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/emir_pkg.sv =====
`timescale 1ns / 1ps
package emir_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    typedef enum logic [3:0] {
        OP_MUL, OP_ADD, OP_SUB, OP_NEG, OP_SC2, OP_SC3, OP_SC4, OP_MOV,
        OP_NEXT, OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        S_X, S_Y, S_N20, S_N11, S_N02, S_A, S_B, S_C, S_ONE, S_ZERO,
        S_Z, S_T0, S_T1
    } src_t;

    typedef enum logic [3:0] {
        D_Z, D_T0, D_T1, D_E0, D_E1, D_E2, D_E3, D_E4, D_E5
    } dst_t;

    typedef enum logic [2:0] {
        ROW_X, ROW_Y, ROW_N20, ROW_N11, ROW_N02, ROW_PRE
    } row_t;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    typedef struct packed {
        op_t  op;
        dst_t dst;
        src_t sa;
        src_t sb;
    } uop_t;

    typedef struct packed {
        logic       idle;
        logic       exec;
        logic       emit;
        logic [2:0] row;
        logic       last;
        uop_t       uop;
    } seq_ctrl_t;

    function automatic uop_t mk(op_t op, dst_t dst, src_t sa, src_t sb);
        uop_t u;
        u.op = op;
        u.dst = dst;
        u.sa = sa;
        u.sb = sb;
        return u;
    endfunction

    // microprogram: one op per step, each row ends with EMIT, the PRE row with NEXT
    function automatic uop_t ucode(row_t row, logic [4:0] step);
        uop_t u;
        u = mk(OP_EMIT, D_T0, S_ZERO, S_ZERO);
        unique case (row)
            ROW_PRE: begin
                unique case (step)
                    5'd0: u = mk(OP_MUL, D_T0, S_A, S_X);
                    5'd1: u = mk(OP_MUL, D_T1, S_B, S_Y);
                    5'd2: u = mk(OP_ADD, D_T0, S_T0, S_T1);
                    5'd3: u = mk(OP_ADD, D_Z, S_T0, S_C);
                    default: u = mk(OP_NEXT, D_T0, S_ZERO, S_ZERO);
                endcase
            end
            ROW_X: begin
                unique case (step)
                    5'd0:  u = mk(OP_NEG, D_E0, S_Z, S_ZERO);
                    5'd1:  u = mk(OP_MOV, D_E1, S_ZERO, S_ZERO);
                    5'd2:  u = mk(OP_MUL, D_T0, S_A, S_N20);
                    5'd3:  u = mk(OP_MUL, D_T1, S_B, S_N11);
                    5'd4:  u = mk(OP_ADD, D_T0, S_T0, S_T1);
                    5'd5:  u = mk(OP_SC4, D_T0, S_T0, S_ZERO);
                    5'd6:  u = mk(OP_MUL, D_T1, S_X, S_Z);
                    5'd7:  u = mk(OP_ADD, D_E2, S_T1, S_T0);
                    5'd8:  u = mk(OP_MUL, D_T0, S_X, S_Y);
                    5'd9:  u = mk(OP_SC4, D_T1, S_N11, S_ZERO);
                    5'd10: u = mk(OP_ADD, D_E3, S_T0, S_T1);
                    5'd11: u = mk(OP_NEG, D_T0, S_ONE, S_ZERO);
                    5'd12: u = mk(OP_MUL, D_T1, S_X, S_X);
                    5'd13: u = mk(OP_SUB, D_T0, S_T0, S_T1);
                    5'd14: u = mk(OP_SC4, D_T1, S_N20, S_ZERO);
                    5'd15: u = mk(OP_SUB, D_E4, S_T0, S_T1);
                    5'd16: u = mk(OP_MOV, D_E5, S_Y, S_ZERO);
                    default: u = mk(OP_EMIT, D_T0, S_ZERO, S_ZERO);
                endcase
            end
            ROW_Y: begin
                unique case (step)
                    5'd0:  u = mk(OP_MOV, D_E0, S_ZERO, S_ZERO);
                    5'd1:  u = mk(OP_NEG, D_E1, S_Z, S_ZERO);
                    5'd2:  u = mk(OP_MUL, D_T0, S_A, S_N11);
                    5'd3:  u = mk(OP_MUL, D_T1, S_B, S_N02);
                    5'd4:  u = mk(OP_ADD, D_T0, S_T0, S_T1);
                    5'd5:  u = mk(OP_SC4, D_T0, S_T0, S_ZERO);
                    5'd6:  u = mk(OP_MUL, D_T1, S_Y, S_Z);
                    5'd7:  u = mk(OP_ADD, D_E2, S_T1, S_T0);
                    5'd8:  u = mk(OP_MUL, D_T0, S_Y, S_Y);
                    5'd9:  u = mk(OP_ADD, D_T0, S_ONE, S_T0);
                    5'd10: u = mk(OP_SC4, D_T1, S_N02, S_ZERO);
                    5'd11: u = mk(OP_ADD, D_E3, S_T0, S_T1);
                    5'd12: u = mk(OP_MUL, D_T0, S_X, S_Y);
                    5'd13: u = mk(OP_NEG, D_T0, S_T0, S_ZERO);
                    5'd14: u = mk(OP_SC4, D_T1, S_N11, S_ZERO);
                    5'd15: u = mk(OP_SUB, D_E4, S_T0, S_T1);
                    5'd16: u = mk(OP_NEG, D_E5, S_X, S_ZERO);
                    default: u = mk(OP_EMIT, D_T0, S_ZERO, S_ZERO);
                endcase
            end
            ROW_N20: begin
                unique case (step)
                    5'd0:  u = mk(OP_MUL, D_T0, S_A, S_N20);
                    5'd1:  u = mk(OP_MUL, D_T1, S_B, S_N11);
                    5'd2:  u = mk(OP_ADD, D_T0, S_T0, S_T1);
                    5'd3:  u = mk(OP_SC2, D_T0, S_T0, S_ZERO);
                    5'd4:  u = mk(OP_NEG, D_E0, S_T0, S_ZERO);
                    5'd5:  u = mk(OP_MOV, D_E1, S_ZERO, S_ZERO);
                    5'd6:  u = mk(OP_MUL, D_T0, S_A, S_X);
                    5'd7:  u = mk(OP_ADD, D_T0, S_Z, S_T0);
                    5'd8:  u = mk(OP_MUL, D_T0, S_T0, S_N20);
                    5'd9:  u = mk(OP_MUL, D_T1, S_B, S_X);
                    5'd10: u = mk(OP_MUL, D_T1, S_T1, S_N11);
                    5'd11: u = mk(OP_ADD, D_T0, S_T0, S_T1);
                    5'd12: u = mk(OP_SC2, D_E2, S_T0, S_ZERO);
                    5'd13: u = mk(OP_MUL, D_T0, S_Y, S_N20);
                    5'd14: u = mk(OP_MUL, D_T1, S_X, S_N11);
                    5'd15: u = mk(OP_ADD, D_T0, S_T0, S_T1);
                    5'd16: u = mk(OP_SC2, D_E3, S_T0, S_ZERO);
                    5'd17: u = mk(OP_MUL, D_T0, S_N20, S_X);
                    5'd18: u = mk(OP_SC4, D_T0, S_T0, S_ZERO);
                    5'd19: u = mk(OP_NEG, D_E4, S_T0, S_ZERO);
                    5'd20: u = mk(OP_SC2, D_E5, S_N11, S_ZERO);
                    default: u = mk(OP_EMIT, D_T0, S_ZERO, S_ZERO);
                endcase
            end
            ROW_N11: begin
                unique case (step)
                    5'd0:  u = mk(OP_MUL, D_T0, S_A, S_N11);
                    5'd1:  u = mk(OP_NEG, D_T0, S_T0, S_ZERO);
                    5'd2:  u = mk(OP_MUL, D_T1, S_B, S_N02);
                    5'd3:  u = mk(OP_SUB, D_E0, S_T0, S_T1);
                    5'd4:  u = mk(OP_MUL, D_T0, S_A, S_N20);
                    5'd5:  u = mk(OP_NEG, D_T0, S_T0, S_ZERO);
                    5'd6:  u = mk(OP_MUL, D_T1, S_B, S_N11);
                    5'd7:  u = mk(OP_SUB, D_E1, S_T0, S_T1);
                    5'd8:  u = mk(OP_MUL, D_T0, S_A, S_Y);
                    5'd9:  u = mk(OP_MUL, D_T0, S_T0, S_N20);
                    5'd10: u = mk(OP_SC3, D_T1, S_Z, S_ZERO);
                    5'd11: u = mk(OP_SUB, D_T1, S_T1, S_C);
                    5'd12: u = mk(OP_MUL, D_T1, S_T1, S_N11);
                    5'd13: u = mk(OP_ADD, D_T0, S_T0, S_T1);
                    5'd14: u = mk(OP_MUL, D_T1, S_B, S_X);
                    5'd15: u = mk(OP_MUL, D_T1, S_T1, S_N02);
                    5'd16: u = mk(OP_ADD, D_E2, S_T0, S_T1);
                    5'd17: u = mk(OP_MUL, D_T0, S_Y, S_N11);
                    5'd18: u = mk(OP_SC3, D_T0, S_T0, S_ZERO);
                    5'd19: u = mk(OP_MUL, D_T1, S_X, S_N02);
                    5'd20: u = mk(OP_ADD, D_E3, S_T0, S_T1);
                    5'd21: u = mk(OP_MUL, D_T0, S_Y, S_N20);
                    5'd22: u = mk(OP_NEG, D_T0, S_T0, S_ZERO);
                    5'd23: u = mk(OP_MUL, D_T1, S_X, S_N11);
                    5'd24: u = mk(OP_SC3, D_T1, S_T1, S_ZERO);
                    5'd25: u = mk(OP_SUB, D_E4, S_T0, S_T1);
                    5'd26: u = mk(OP_SUB, D_E5, S_N02, S_N20);
                    default: u = mk(OP_EMIT, D_T0, S_ZERO, S_ZERO);
                endcase
            end
            ROW_N02: begin
                unique case (step)
                    5'd0:  u = mk(OP_MOV, D_E0, S_ZERO, S_ZERO);
                    5'd1:  u = mk(OP_MUL, D_T0, S_A, S_N11);
                    5'd2:  u = mk(OP_MUL, D_T1, S_B, S_N02);
                    5'd3:  u = mk(OP_ADD, D_T0, S_T0, S_T1);
                    5'd4:  u = mk(OP_SC2, D_T0, S_T0, S_ZERO);
                    5'd5:  u = mk(OP_NEG, D_E1, S_T0, S_ZERO);
                    5'd6:  u = mk(OP_MUL, D_T0, S_B, S_Y);
                    5'd7:  u = mk(OP_ADD, D_T0, S_Z, S_T0);
                    5'd8:  u = mk(OP_MUL, D_T0, S_T0, S_N02);
                    5'd9:  u = mk(OP_MUL, D_T1, S_A, S_Y);
                    5'd10: u = mk(OP_MUL, D_T1, S_T1, S_N11);
                    5'd11: u = mk(OP_ADD, D_T0, S_T0, S_T1);
                    5'd12: u = mk(OP_SC2, D_E2, S_T0, S_ZERO);
                    5'd13: u = mk(OP_MUL, D_T0, S_Y, S_N02);
                    5'd14: u = mk(OP_SC4, D_E3, S_T0, S_ZERO);
                    5'd15: u = mk(OP_MUL, D_T0, S_Y, S_N11);
                    5'd16: u = mk(OP_MUL, D_T1, S_X, S_N02);
                    5'd17: u = mk(OP_ADD, D_T0, S_T0, S_T1);
                    5'd18: u = mk(OP_SC2, D_T0, S_T0, S_ZERO);
                    5'd19: u = mk(OP_NEG, D_E4, S_T0, S_ZERO);
                    5'd20: u = mk(OP_SC2, D_T0, S_N11, S_ZERO);
                    5'd21: u = mk(OP_NEG, D_E5, S_T0, S_ZERO);
                    default: u = mk(OP_EMIT, D_T0, S_ZERO, S_ZERO);
                endcase
            end
            default: u = mk(OP_EMIT, D_T0, S_ZERO, S_ZERO);
        endcase
        return u;
    endfunction

    // lowest set bit of a row mask
    function automatic row_t first_row(logic [4:0] mask);
        row_t r;
        r = ROW_N02;
        priority if (mask[0]) r = ROW_X;
        else if (mask[1]) r = ROW_Y;
        else if (mask[2]) r = ROW_N20;
        else if (mask[3]) r = ROW_N11;
        else r = ROW_N02;
        return r;
    endfunction

endpackage

// ===== hdl/emir_alu.sv =====
`timescale 1ns / 1ps
module emir_alu (
    input  emir_pkg::op_t       op,
    input  logic signed [31:0]  opa,
    input  logic signed [31:0]  opb,
    output logic signed [31:0]  res
);
    import emir_pkg::*;

    logic signed [63:0] prod;
    logic signed [63:0] prod_sh;
    logic signed [33:0] wa;
    logic signed [33:0] wb;
    logic signed [33:0] wide;

    function automatic logic signed [31:0] sat34(logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'(Q_MAX)) r = Q_MAX;
        else if (v < 34'(Q_MIN)) r = Q_MIN;
        else r = v[31:0];
        return r;
    endfunction

    always_comb begin
        wa = 34'(opa);
        wb = 34'(opb);
        prod = 64'(opa) * 64'(opb);
        prod_sh = prod >>> FRAC_BITS;   // floor
        wide = '0;
        unique case (op)
            OP_ADD: wide = wa + wb;
            OP_SUB: wide = wa - wb;
            OP_NEG: wide = -wa;
            OP_SC2: wide = wa <<< 1;
            OP_SC3: wide = (wa <<< 1) + wa;
            OP_SC4: wide = wa <<< 2;
            default: wide = wa;
        endcase
        if (op == OP_MUL) begin
            if (prod_sh > 64'(Q_MAX)) res = Q_MAX;
            else if (prod_sh < 64'(Q_MIN)) res = Q_MIN;
            else res = prod_sh[31:0];
        end else begin
            res = sat34(wide);
        end
    end
endmodule

// ===== hdl/emir_seq.sv =====
`timescale 1ns / 1ps
module emir_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [4:0]          mask,
    input  logic                out_busy,
    output emir_pkg::seq_ctrl_t ctrl
);
    import emir_pkg::*;

    state_t     state_reg, state_next;
    row_t       row_reg;
    logic [4:0] step_reg;
    logic [4:0] left_reg;
    logic [4:0] left_after;
    uop_t       uop;
    logic       stall;
    logic       exec;
    logic       jump;

    assign uop = ucode(row_reg, step_reg);
    assign stall = (uop.op == OP_EMIT) && out_busy;
    assign exec = (state_reg == ST_RUN) && !stall;
    assign jump = (uop.op == OP_EMIT) || (uop.op == OP_NEXT);
    assign left_after = (uop.op == OP_EMIT) ? (left_reg & ~(5'd1 << row_reg)) : left_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start && (mask != 5'd0)) state_next = ST_RUN;
            ST_RUN:  if (exec && jump && (left_after == 5'd0)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.idle = (state_reg == ST_IDLE);
        ctrl.exec = exec;
        ctrl.emit = exec && (uop.op == OP_EMIT);
        ctrl.row = row_reg;
        ctrl.last = (left_after == 5'd0);
        ctrl.uop = uop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg <= ROW_PRE;
            step_reg <= '0;
            left_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && start) begin
                row_reg <= ROW_PRE;
                step_reg <= '0;
                left_reg <= mask;
            end else if (exec) begin
                if (jump) begin
                    row_reg <= first_row(left_after);
                    step_reg <= '0;
                    left_reg <= left_after;
                end else begin
                    step_reg <= step_reg + 5'd1;
                end
            end
        end
    end
endmodule

// ===== hdl/ellipse_moment_interaction_rows_core.sv =====
`timescale 1ns / 1ps
// Ellipse moment interaction rows.
// Input channel (s_*): one word holds centroid x/y, moments n20/n11/n02 and
// a 5-bit row mask. Output channel (m_*): one word per selected row, in order
// x, y, n20, n11, n02, with six Q16.16 entries, the row index and last_row.
// Plane coefficients A, B, C are written through cfg_we/cfg_index/cfg_wdata,
// by the user only while idle, not enforced by the block; index 3 is ignored.
// One shared ALU (32x32 multiply with floor and saturation, or saturating
// add/sub/neg/scale) runs one micro-op per cycle under a microcoded
// sequencer, except while the emit step waits on a stalled receiver. Inverse
// depth is computed first, then each selected row in turn; s_ready stays low
// until the last row is emitted.
// s_ready is high only while idle; a zero mask is taken and gives no word.
// A finished row sits in the output register; if the receiver stalls, the
// sequencer waits at the emit step of the next row.
// Reset: C returns to 1.0, A and B to 0, the output register empties.
module ellipse_moment_interaction_rows_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic signed [31:0]  cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_center_x,
    input  logic signed [31:0]  s_center_y,
    input  logic signed [31:0]  s_moment_20,
    input  logic signed [31:0]  s_moment_11,
    input  logic signed [31:0]  s_moment_02,
    input  logic [4:0]          s_row_mask,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_entry_vx,
    output logic signed [31:0]  m_entry_vy,
    output logic signed [31:0]  m_entry_vz,
    output logic signed [31:0]  m_entry_wx,
    output logic signed [31:0]  m_entry_wy,
    output logic signed [31:0]  m_entry_wz,
    output logic [2:0]          m_row_index,
    output logic                m_last_row
);
    import emir_pkg::*;
    `include "assert_macros.svh"

    localparam logic [1:0] CFG_A = 2'd0;
    localparam logic [1:0] CFG_B = 2'd1;
    localparam logic [1:0] CFG_C = 2'd2;

    seq_ctrl_t ctrl;
    logic      start;
    logic      out_busy;

    // config registers
    logic signed [31:0] a_reg, b_reg, c_reg;
    // captured word
    logic signed [31:0] x_reg, y_reg, n20_reg, n11_reg, n02_reg;
    // scratch and row entries
    logic signed [31:0] z_reg, t0_reg, t1_reg;
    logic signed [31:0] e0_reg, e1_reg, e2_reg, e3_reg, e4_reg, e5_reg;
    logic signed [31:0] opa, opb, res;
    logic               m_valid_reg, m_valid_next;

    assign s_ready = ctrl.idle;
    assign start = s_valid && s_ready;
    assign out_busy = m_valid_reg && !m_ready;

    emir_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .mask     (s_row_mask),
        .out_busy (out_busy),
        .ctrl     (ctrl)
    );

    function automatic logic signed [31:0] pick(
        src_t s,
        logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] n20,
        logic signed [31:0] n11, logic signed [31:0] n02, logic signed [31:0] a,
        logic signed [31:0] b, logic signed [31:0] c, logic signed [31:0] z,
        logic signed [31:0] t0, logic signed [31:0] t1);
        logic signed [31:0] v;
        unique case (s)
            S_X:    v = x;
            S_Y:    v = y;
            S_N20:  v = n20;
            S_N11:  v = n11;
            S_N02:  v = n02;
            S_A:    v = a;
            S_B:    v = b;
            S_C:    v = c;
            S_ONE:  v = Q_ONE;
            S_Z:    v = z;
            S_T0:   v = t0;
            S_T1:   v = t1;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign opa = pick(ctrl.uop.sa, x_reg, y_reg, n20_reg, n11_reg, n02_reg,
                      a_reg, b_reg, c_reg, z_reg, t0_reg, t1_reg);
    assign opb = pick(ctrl.uop.sb, x_reg, y_reg, n20_reg, n11_reg, n02_reg,
                      a_reg, b_reg, c_reg, z_reg, t0_reg, t1_reg);

    emir_alu u_alu (
        .op  (ctrl.uop.op),
        .opa (opa),
        .opb (opb),
        .res (res)
    );

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= Q_ONE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_A: a_reg <= cfg_wdata;
                CFG_B: b_reg <= cfg_wdata;
                CFG_C: c_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // operand capture
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= s_center_x;
            y_reg <= s_center_y;
            n20_reg <= s_moment_20;
            n11_reg <= s_moment_11;
            n02_reg <= s_moment_02;
        end
    end

    // writeback of the shared ALU
    always_ff @(posedge aclk) begin
        if (ctrl.exec && !(ctrl.uop.op == OP_EMIT || ctrl.uop.op == OP_NEXT)) begin
            unique case (ctrl.uop.dst)
                D_Z:  z_reg <= res;
                D_T0: t0_reg <= res;
                D_T1: t1_reg <= res;
                D_E0: e0_reg <= res;
                D_E1: e1_reg <= res;
                D_E2: e2_reg <= res;
                D_E3: e3_reg <= res;
                D_E4: e4_reg <= res;
                D_E5: e5_reg <= res;
                default: ;
            endcase
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.emit) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            m_entry_vx <= e0_reg;
            m_entry_vy <= e1_reg;
            m_entry_vz <= e2_reg;
            m_entry_wx <= e3_reg;
            m_entry_wy <= e4_reg;
            m_entry_wz <= e5_reg;
            m_row_index <= ctrl.row;
            m_last_row <= ctrl.last;
        end
    end

    assign m_valid = m_valid_reg;

    `EMI_ASSERT_IMP(a_emit_free, aclk, aresetn, ctrl.emit, !(m_valid_reg && !m_ready))
    `EMI_ASSERT_NXT(a_busy_after_start, aclk, aresetn, start && (s_row_mask != 5'd0), !s_ready)
    `EMI_ASSERT_IMP(a_row_range, aclk, aresetn, m_valid_reg, m_row_index <= 3'd4)
    `EMI_ASSERT_IMP(a_idle_no_exec, aclk, aresetn, ctrl.idle, !ctrl.exec)
endmodule
